// File: hw/rtl/imu_pkt_pkg.sv
// Package for the IMU packet deframer: framing constants, phase and token
// types shared by the front end, the token queue and the record walker.
// No dependencies.
package imu_pkt_pkg;

    localparam logic [7:0] SYNC_FIRST  = 8'h59;
    localparam logic [7:0] SYNC_SECOND = 8'h53;

    // capture window of a required record, in value bytes
    localparam int unsigned VALUE_BYTES = 12;
    localparam int unsigned OFFSET_W    = $clog2(VALUE_BYTES + 1);

    // configuration registers
    localparam int unsigned CFG_INDEX_W = 8;
    localparam logic [CFG_INDEX_W-1:0] CFG_ANGLE_ID = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_RATE_ID  = 8'd1;
    localparam logic [7:0] ANGLE_ID_RESET = 8'h40;
    localparam logic [7:0] RATE_ID_RESET  = 8'h20;

    // result status codes
    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_CHKSUM  = 2'd1;
    localparam logic [1:0] STATUS_MISSING = 2'd2;

    // token queue between front and back
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

    typedef enum logic [2:0] {
        PH_SYNC1,
        PH_SYNC2,
        PH_HDR2,
        PH_HDR3,
        PH_LEN,
        PH_PAYLOAD,
        PH_CHK1,
        PH_CHK2
    } t_frame_phase;

    typedef enum logic [1:0] {
        REC_ID,
        REC_LEN,
        REC_VALUE
    } t_rec_phase;

    typedef enum logic [1:0] {
        TOK_START,   // length byte seen: new payload begins
        TOK_BYTE,    // one payload byte in data
        TOK_END      // packet end, data[0] = checksum matched
    } t_tok_kind;

    typedef struct packed {
        t_tok_kind  kind;
        logic [7:0] data;
    } t_token;

    typedef struct packed {
        logic full;
        logic not_empty;
    } t_queue_status;

endpackage

// File: hw/rtl/imu_pkt_front.sv
// Front end: sync hunt, header and length parsing, running checksum.
// Turns accepted bytes into tokens for the queue. Uses imu_pkt_pkg.
module imu_pkt_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [7:0]            i_rx_byte,
    input  imu_pkt_pkg::t_queue_status i_q_status,
    output logic                  o_push,
    output imu_pkt_pkg::t_token   o_push_tok
);

    imu_pkt_pkg::t_frame_phase r_phase, n_phase;
    logic [7:0] r_pos, n_pos;
    logic [7:0] r_len, n_len;
    logic [7:0] r_sum_low, n_sum_low;
    logic [7:0] r_sum_high, n_sum_high;
    logic [7:0] r_first_chk, n_first_chk;

    logic [7:0] sum_low_add;
    logic [7:0] sum_high_add;
    logic [7:0] pos_inc;
    logic       take;

    assign o_ready      = !i_q_status.full;
    assign take         = i_valid && o_ready;
    assign sum_low_add  = r_sum_low + i_rx_byte;
    assign sum_high_add = r_sum_high + sum_low_add;
    assign pos_inc      = r_pos + 8'd1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= imu_pkt_pkg::PH_SYNC1;
            r_pos       <= '0;
            r_len       <= '0;
            r_sum_low   <= '0;
            r_sum_high  <= '0;
            r_first_chk <= '0;
        end else begin
            r_phase     <= n_phase;
            r_pos       <= n_pos;
            r_len       <= n_len;
            r_sum_low   <= n_sum_low;
            r_sum_high  <= n_sum_high;
            r_first_chk <= n_first_chk;
        end
    end

    always_comb begin
        n_phase         = r_phase;
        n_pos           = r_pos;
        n_len           = r_len;
        n_sum_low       = r_sum_low;
        n_sum_high      = r_sum_high;
        n_first_chk     = r_first_chk;
        o_push          = 1'b0;
        o_push_tok.kind = imu_pkt_pkg::TOK_BYTE;
        o_push_tok.data = i_rx_byte;
        if (take) begin
            unique case (r_phase)
                imu_pkt_pkg::PH_SYNC1: begin
                    if (i_rx_byte == imu_pkt_pkg::SYNC_FIRST) n_phase = imu_pkt_pkg::PH_SYNC2;
                end
                imu_pkt_pkg::PH_SYNC2: begin
                    // a repeated first sync byte keeps us waiting for the second
                    if (i_rx_byte == imu_pkt_pkg::SYNC_SECOND) begin
                        n_sum_low  = '0;
                        n_sum_high = '0;
                        n_phase    = imu_pkt_pkg::PH_HDR2;
                    end else if (i_rx_byte != imu_pkt_pkg::SYNC_FIRST) begin
                        n_phase = imu_pkt_pkg::PH_SYNC1;
                    end
                end
                imu_pkt_pkg::PH_HDR2: begin
                    n_sum_low  = sum_low_add;
                    n_sum_high = sum_high_add;
                    n_phase    = imu_pkt_pkg::PH_HDR3;
                end
                imu_pkt_pkg::PH_HDR3: begin
                    n_sum_low  = sum_low_add;
                    n_sum_high = sum_high_add;
                    n_phase    = imu_pkt_pkg::PH_LEN;
                end
                imu_pkt_pkg::PH_LEN: begin
                    n_sum_low       = sum_low_add;
                    n_sum_high      = sum_high_add;
                    n_len           = i_rx_byte;
                    n_pos           = '0;
                    o_push          = 1'b1;
                    o_push_tok.kind = imu_pkt_pkg::TOK_START;
                    n_phase         = (i_rx_byte == 8'd0) ? imu_pkt_pkg::PH_CHK1
                                                          : imu_pkt_pkg::PH_PAYLOAD;
                end
                imu_pkt_pkg::PH_PAYLOAD: begin
                    n_sum_low  = sum_low_add;
                    n_sum_high = sum_high_add;
                    n_pos      = pos_inc;
                    o_push     = 1'b1;
                    if (pos_inc == r_len) n_phase = imu_pkt_pkg::PH_CHK1;
                end
                imu_pkt_pkg::PH_CHK1: begin
                    n_first_chk = i_rx_byte;
                    n_phase     = imu_pkt_pkg::PH_CHK2;
                end
                imu_pkt_pkg::PH_CHK2: begin
                    o_push          = 1'b1;
                    o_push_tok.kind = imu_pkt_pkg::TOK_END;
                    o_push_tok.data = {7'd0, (r_first_chk == r_sum_low) &&
                                             (i_rx_byte == r_sum_high)};
                    n_phase         = imu_pkt_pkg::PH_SYNC1;
                end
            endcase
        end
    end

endmodule

// File: hw/rtl/imu_pkt_queue.sv
// Short token queue between front end and record walker.
// Register-based FIFO; depth from imu_pkt_pkg.
module imu_pkt_queue (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push,
    input  imu_pkt_pkg::t_token        i_push_tok,
    input  logic                       i_pop,
    output imu_pkt_pkg::t_token        o_head_tok,
    output imu_pkt_pkg::t_queue_status o_status
);

    localparam int unsigned PW = imu_pkt_pkg::QUEUE_PTR_W;

    imu_pkt_pkg::t_token r_mem [imu_pkt_pkg::QUEUE_DEPTH];
    logic [PW-1:0] r_wr_ptr, n_wr_ptr;
    logic [PW-1:0] r_rd_ptr, n_rd_ptr;
    logic [PW:0]   r_count, n_count;
    logic          do_push;
    logic          do_pop;

    assign o_status.full      = (r_count == (PW+1)'(imu_pkt_pkg::QUEUE_DEPTH));
    assign o_status.not_empty = (r_count != '0);
    assign o_head_tok         = r_mem[r_rd_ptr];
    assign do_push            = i_push && !o_status.full;
    assign do_pop             = i_pop && o_status.not_empty;

    always_comb begin
        n_wr_ptr = do_push ? r_wr_ptr + PW'(1) : r_wr_ptr;
        n_rd_ptr = do_pop ? r_rd_ptr + PW'(1) : r_rd_ptr;
        n_count  = r_count;
        if (do_push && !do_pop) n_count = r_count + (PW+1)'(1);
        else if (do_pop && !do_push) n_count = r_count - (PW+1)'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wr_ptr] <= i_push_tok;
    end

endmodule

// File: hw/rtl/imu_pkt_back.sv
// Back end: record id/length/value walker, value capture, result register
// and the two record id registers. Consumes tokens; uses imu_pkt_pkg.
module imu_pkt_back (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_valid,
    input  logic [imu_pkt_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [7:0]                 i_cfg_data,
    input  imu_pkt_pkg::t_token        i_head_tok,
    input  imu_pkt_pkg::t_queue_status i_q_status,
    output logic                       o_pop,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [1:0]                 o_status,
    output logic signed [31:0]         o_pitch,
    output logic signed [31:0]         o_roll,
    output logic signed [31:0]         o_yaw,
    output logic signed [31:0]         o_rate_x,
    output logic signed [31:0]         o_rate_y,
    output logic signed [31:0]         o_rate_z
);

    localparam int unsigned NB = imu_pkt_pkg::VALUE_BYTES;
    localparam int unsigned OW = imu_pkt_pkg::OFFSET_W;

    logic [7:0] r_angle_id;
    logic [7:0] r_rate_id;

    imu_pkt_pkg::t_rec_phase r_rec_phase, n_rec_phase;
    logic [1:0]    r_kind, n_kind;          // bit 0 angle, bit 1 rate
    logic [7:0]    r_remaining, n_remaining;
    logic [OW-1:0] r_offset, n_offset;      // saturates at NB
    logic [1:0]    r_found, n_found;
    logic [1:0]    r_complete, n_complete;

    logic [7:0] r_angle_b [NB];
    logic [7:0] r_rate_b  [NB];

    logic        r_out_valid;
    logic [1:0]  r_status;
    logic [31:0] r_val [6];

    logic       out_free;
    logic       is_end;
    logic       in_window;
    logic       wr_angle;
    logic       wr_rate;
    logic [1:0] end_status;
    logic [31:0] cap_val [6];

    assign out_free  = !r_out_valid || i_ready;
    assign is_end    = (i_head_tok.kind == imu_pkt_pkg::TOK_END);
    assign o_pop     = i_q_status.not_empty && (!is_end || out_free);
    assign in_window = (r_offset < OW'(NB));
    assign wr_angle  = o_pop && (i_head_tok.kind == imu_pkt_pkg::TOK_BYTE)
                       && (r_rec_phase == imu_pkt_pkg::REC_VALUE) && in_window && r_kind[0];
    assign wr_rate   = o_pop && (i_head_tok.kind == imu_pkt_pkg::TOK_BYTE)
                       && (r_rec_phase == imu_pkt_pkg::REC_VALUE) && in_window && r_kind[1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_angle_id <= imu_pkt_pkg::ANGLE_ID_RESET;
            r_rate_id  <= imu_pkt_pkg::RATE_ID_RESET;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == imu_pkt_pkg::CFG_ANGLE_ID) r_angle_id <= i_cfg_data;
            else if (i_cfg_index == imu_pkt_pkg::CFG_RATE_ID) r_rate_id <= i_cfg_data;
        end
    end

    always_comb begin
        n_rec_phase = r_rec_phase;
        n_kind      = r_kind;
        n_remaining = r_remaining;
        n_offset    = r_offset;
        n_found     = r_found;
        n_complete  = r_complete;
        if (o_pop) begin
            case (i_head_tok.kind)
                imu_pkt_pkg::TOK_START: begin
                    n_rec_phase = imu_pkt_pkg::REC_ID;
                    n_kind      = '0;
                    n_remaining = '0;
                    n_offset    = '0;
                    n_found     = '0;
                    n_complete  = '0;
                end
                imu_pkt_pkg::TOK_BYTE: begin
                    unique case (r_rec_phase)
                        imu_pkt_pkg::REC_ID: begin
                            // only the first record with each id is captured
                            n_kind[0]   = (i_head_tok.data == r_angle_id) && !r_found[0];
                            n_kind[1]   = (i_head_tok.data == r_rate_id) && !r_found[1];
                            n_found     = r_found | n_kind;
                            n_rec_phase = imu_pkt_pkg::REC_LEN;
                        end
                        imu_pkt_pkg::REC_LEN: begin
                            n_remaining = i_head_tok.data;
                            n_offset    = '0;
                            n_rec_phase = (i_head_tok.data == 8'd0) ? imu_pkt_pkg::REC_ID
                                                                    : imu_pkt_pkg::REC_VALUE;
                        end
                        default: begin
                            if (r_offset == OW'(NB - 1)) n_complete = r_complete | r_kind;
                            if (in_window) n_offset = r_offset + OW'(1);
                            n_remaining = r_remaining - 8'd1;
                            if (r_remaining == 8'd1) n_rec_phase = imu_pkt_pkg::REC_ID;
                        end
                    endcase
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rec_phase <= imu_pkt_pkg::REC_ID;
            r_kind      <= '0;
            r_remaining <= '0;
            r_offset    <= '0;
            r_found     <= '0;
            r_complete  <= '0;
        end else begin
            r_rec_phase <= n_rec_phase;
            r_kind      <= n_kind;
            r_remaining <= n_remaining;
            r_offset    <= n_offset;
            r_found     <= n_found;
            r_complete  <= n_complete;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_angle) r_angle_b[r_offset] <= i_head_tok.data;
        if (wr_rate)  r_rate_b[r_offset]  <= i_head_tok.data;
    end

    // little-endian words out of the captured bytes
    always_comb begin
        for (int w = 0; w < 3; w++) begin
            cap_val[w]     = {r_angle_b[4*w+3], r_angle_b[4*w+2],
                              r_angle_b[4*w+1], r_angle_b[4*w]};
            cap_val[w + 3] = {r_rate_b[4*w+3], r_rate_b[4*w+2],
                              r_rate_b[4*w+1], r_rate_b[4*w]};
        end
    end

    always_comb begin
        if (!i_head_tok.data[0]) end_status = imu_pkt_pkg::STATUS_CHKSUM;
        else if (r_complete != 2'b11) end_status = imu_pkt_pkg::STATUS_MISSING;
        else end_status = imu_pkt_pkg::STATUS_OK;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_pop && is_end) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && is_end) begin
            r_status <= end_status;
            for (int k = 0; k < 6; k++) begin
                r_val[k] <= (end_status == imu_pkt_pkg::STATUS_OK) ? cap_val[k] : 32'd0;
            end
        end
    end

    assign o_valid  = r_out_valid;
    assign o_status = r_status;
    assign o_pitch  = $signed(r_val[0]);
    assign o_roll   = $signed(r_val[1]);
    assign o_yaw    = $signed(r_val[2]);
    assign o_rate_x = $signed(r_val[3]);
    assign o_rate_y = $signed(r_val[4]);
    assign o_rate_z = $signed(r_val[5]);

endmodule

// File: hw/rtl/imu_packet_deframer.sv
// IMU packet deframer. One received byte is taken per clock cycle, sustained,
// for as long as the four-word token queue between the framing front end and
// the record walker has room; the walker drains one word per cycle, so the
// input only stalls while a finished result sits unread in the output
// register and the queue fills up behind it. A result is registered once its
// end word leaves the queue and holds until taken. Status 0 means good checksum
// and both required records captured; status 1 is a checksum mismatch; status 2
// a missing or short record. On a nonzero status all six values read zero.
// Record ids are to be written through the config port (index 0 angle id, index
// 1 rate id) only while the block is idle; the block does not enforce this.
// Depends on imu_pkt_pkg, imu_pkt_front, imu_pkt_queue, imu_pkt_back.
module imu_packet_deframer (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [7:0]         i_rx_byte,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [1:0]         o_status,
    output logic signed [31:0] o_pitch,
    output logic signed [31:0] o_roll,
    output logic signed [31:0] o_yaw,
    output logic signed [31:0] o_rate_x,
    output logic signed [31:0] o_rate_y,
    output logic signed [31:0] o_rate_z,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [imu_pkt_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [7:0]         i_cfg_data
);

    logic                       push;
    imu_pkt_pkg::t_token        push_tok;
    logic                       pop;
    imu_pkt_pkg::t_token        head_tok;
    imu_pkt_pkg::t_queue_status q_status;

    assign o_cfg_ready = 1'b1;

    imu_pkt_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_rx_byte  (i_rx_byte),
        .i_q_status (q_status),
        .o_push     (push),
        .o_push_tok (push_tok)
    );

    imu_pkt_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_push_tok (push_tok),
        .i_pop      (pop),
        .o_head_tok (head_tok),
        .o_status   (q_status)
    );

    imu_pkt_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_head_tok  (head_tok),
        .i_q_status  (q_status),
        .o_pop       (pop),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_status    (o_status),
        .o_pitch     (o_pitch),
        .o_roll      (o_roll),
        .o_yaw       (o_yaw),
        .o_rate_x    (o_rate_x),
        .o_rate_y    (o_rate_y),
        .o_rate_z    (o_rate_z)
    );

endmodule

// File: hw/rtl/imu_pkt_checker.sv
// Port-level checks for imu_packet_deframer, attached with bind.
// Depends on imu_packet_deframer's ports and imu_pkt_pkg.
module imu_pkt_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_valid,
    input logic               i_ready,
    input logic [1:0]         o_status,
    input logic signed [31:0] o_pitch,
    input logic signed [31:0] o_roll,
    input logic signed [31:0] o_yaw,
    input logic signed [31:0] o_rate_x,
    input logic signed [31:0] o_rate_y,
    input logic signed [31:0] o_rate_z
);

    logic vals_zero;
    assign vals_zero = (o_pitch == 0) && (o_roll == 0) && (o_yaw == 0) &&
                       (o_rate_x == 0) && (o_rate_y == 0) && (o_rate_z == 0);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_status) && $stable(o_pitch)
                                && $stable(o_rate_z))
        else $error("result word changed while stalled");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status != imu_pkt_pkg::STATUS_OK) |-> vals_zero)
        else $error("nonzero values on failed packet");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_status == imu_pkt_pkg::STATUS_OK) ||
                    (o_status == imu_pkt_pkg::STATUS_CHKSUM) ||
                    (o_status == imu_pkt_pkg::STATUS_MISSING))
        else $error("undefined status code");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

endmodule

bind imu_packet_deframer imu_pkt_checker u_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .o_valid  (o_valid),
    .i_ready  (i_ready),
    .o_status (o_status),
    .o_pitch  (o_pitch),
    .o_roll   (o_roll),
    .o_yaw    (o_yaw),
    .o_rate_x (o_rate_x),
    .o_rate_y (o_rate_y),
    .o_rate_z (o_rate_z)
);
